// ----- hw/rtl/adpcm_ase_pkg.sv -----
// Shared widths, register indexes, reset values and types of the ADPCM step encoder.
package adpcm_ase_pkg;

    // Channel payload widths
    localparam int SAMPLE_W   = 16;
    localparam int CODE_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Datapath widths: prediction, step and history entries are 40 bits
    localparam int ACC_W      = 40;
    localparam int MAX_WINDOW = 32;
    localparam int HIST_AW    = $clog2(MAX_WINDOW);
    localparam int WIN_W      = 6;
    localparam int SH_W       = 4;
    localparam int SUM_W      = ACC_W + HIST_AW;
    localparam int DIVD_W     = SUM_W + 15;
    localparam int DIVS_W     = ACC_W;
    localparam int DIV_CNT_W  = $clog2(DIVD_W + 1);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CODE_MAX      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_MIN      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PREDICT_SHIFT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ADAPT_SHIFT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_FLOOR    = 3'd5;

    // Register reset values
    localparam logic [6:0]        RST_CODE_MAX      = 7'd7;
    localparam logic signed [7:0] RST_CODE_MIN      = -8'sd8;
    localparam logic [SH_W-1:0]   RST_PREDICT_SHIFT = 4'd14;
    localparam logic [SH_W-1:0]   RST_ADAPT_SHIFT   = 4'd14;
    localparam logic [WIN_W-1:0]  RST_WINDOW_LENGTH = 6'd8;
    localparam logic [15:0]       RST_STEP_FLOOR    = 16'd1;

    // Divider control from the sequencer
    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] iters;
    } t_div_req;

endpackage

// ----- hw/rtl/adpcm_ase_if.sv -----
// Handshake channels of the ADPCM step encoder: sample in, code out, register writes.
interface adpcm_ase_sample_if import adpcm_ase_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

interface adpcm_ase_code_if import adpcm_ase_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [CODE_W-1:0] code;

    modport source (output valid, output code, input ready);
    modport sink (input valid, input code, output ready);
endinterface

interface adpcm_ase_cfg_if import adpcm_ase_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/adpcm_ase_div.sv -----
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
module adpcm_ase_div import adpcm_ase_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_div_req          i_req,
    input  logic [DIVD_W-1:0] i_dividend,
    input  logic [DIVS_W-1:0] i_divisor,
    output logic              o_done,
    output logic [DIVD_W-1:0] o_quot
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIVS_W-1:0]    r_rem;
    logic [DIVD_W-1:0]    r_quo;
    logic [DIVS_W-1:0]    r_div;

    logic [DIVS_W:0]      shifted;
    logic [DIVS_W+1:0]    trial;

    // Shift one dividend bit into the partial remainder and try the subtraction
    assign shifted = {r_rem, r_quo[DIVD_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, r_div};

    // Control: busy flag, iteration count and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.iters;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: load operands, then one restoring step per cycle
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            if (!trial[DIVS_W+1]) begin
                r_rem <= trial[DIVS_W-1:0];
            end else begin
                r_rem <= shifted[DIVS_W-1:0];
            end
            r_quo <= {r_quo[DIVD_W-2:0], ~trial[DIVS_W+1]};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

// ----- hw/rtl/adpcm_adaptive_step_encoder_unit.sv -----
// Backward-adaptive ADPCM encoder for one subband: sequencer, history memory, step update.
//
// Usage:
//   i_sample carries one 16-bit signed subband sample per item; o_code returns one
//   8-bit signed code per sample, in order. i_cfg writes the six registers (index
//   0 code_max .. 5 step_floor); it is always ready, and writes are meant for idle
//   periods only. Indexes above 5 are ignored.
// Timing:
//   A new sample is accepted only after the previous item has finished its step
//   update. The pace is set by the shared one-bit-per-cycle divider (prediction
//   error over step, then the window mean) and by the walk over the 32-entry
//   history memory, one entry read per cycle.
//   The code is loaded into the output register after the first divide and the clip.
// Stall:
//   The code sits in an output register. The encoder finishes the adaptation of an
//   item and takes the next sample while the code waits; that next item holds just
//   before its code would be loaded until the receiver takes the earlier one.
// Reset:
//   Synchronous, active low. Registers return to their defaults, the prediction to
//   zero, the step to 1 and the history to all zero through per-entry valid bits,
//   so no clearing pass is needed.
module adpcm_adaptive_step_encoder_unit import adpcm_ase_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    adpcm_ase_sample_if.sink          i_sample,
    adpcm_ase_code_if.source          o_code,
    adpcm_ase_cfg_if.sink             i_cfg
);

    // Sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DIFF = 4'd1;
    localparam logic [3:0] S_DIV1 = 4'd2;
    localparam logic [3:0] S_CLIP = 4'd3;
    localparam logic [3:0] S_MUL  = 4'd4;
    localparam logic [3:0] S_WR   = 4'd5;
    localparam logic [3:0] S_PRED = 4'd6;
    localparam logic [3:0] S_SUM  = 4'd7;
    localparam logic [3:0] S_DIV2 = 4'd8;
    localparam logic [3:0] S_STEP = 4'd9;

    // Configuration registers
    logic [6:0]        r_code_max;
    logic signed [7:0] r_code_min;
    logic [SH_W-1:0]   r_pred_shift;
    logic [SH_W-1:0]   r_adapt_shift;
    logic [WIN_W-1:0]  r_win_len;
    logic [15:0]       r_step_floor;

    // Sequencer and encoder state
    logic [3:0]                 r_state;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic signed [ACC_W-1:0]    r_pred;
    logic [ACC_W-1:0]           r_step;
    logic                       r_neg;
    logic signed [CODE_W-1:0]   r_z;
    logic signed [ACC_W+8:0]    r_prod;
    logic signed [ACC_W:0]      r_recon;
    logic [HIST_AW-1:0]         r_pos;
    logic [HIST_AW-1:0]         r_idx;
    logic [WIN_W-1:0]           r_cnt;
    logic                       r_pend;
    logic [SUM_W-1:0]           r_sum;
    logic                       r_out_valid;
    logic signed [CODE_W-1:0]   r_code;

    // History memory with per-entry valid bits
    logic [ACC_W-1:0]      r_hist [MAX_WINDOW];
    logic [MAX_WINDOW-1:0] r_hvalid;
    logic [ACC_W-1:0]      r_rd_data;
    logic                  r_rd_vld;

    // Combinational signals
    logic                       in_acc;
    logic                       out_acc;
    logic                       slot_free;
    logic [WIN_W-1:0]           wl_eff;
    logic signed [ACC_W:0]      diff;
    logic [ACC_W:0]             diff_mag;
    logic [ACC_W-1:0]           quot_lo;
    logic [7:0]                 neg_lim;
    logic signed [CODE_W-1:0]   n_z;
    logic signed [ACC_W:0]      step_s;
    logic signed [ACC_W-1:0]    n_dq;
    logic [HIST_AW-1:0]         pos_nxt;
    logic [HIST_AW-1:0]         idx_dec;
    logic signed [ACC_W+15:0]   recon_sh;
    logic signed [ACC_W+16:0]   recon_rnd;
    logic signed [ACC_W+1:0]    pred_q;
    logic signed [ACC_W-1:0]    n_pred;
    logic                       issue;
    logic [ACC_W-1:0]           hist_v;
    logic [ACC_W-1:0]           hist_abs;
    logic [DIVD_W:0]            power_rnd;
    logic [DIVD_W-15:0]         ns;
    logic [15:0]                step_fl;
    logic [ACC_W-1:0]           n_step;
    logic                       rd_en;
    logic                       sum_done;

    // Divider interface
    t_div_req          div_req;
    logic [DIVD_W-1:0] div_dividend;
    logic [DIVS_W-1:0] div_divisor;
    logic              div_done;
    logic [DIVD_W-1:0] div_quot;

    // Handshakes
    assign i_sample.ready = (r_state == S_IDLE);
    assign i_cfg.ready    = 1'b1;
    assign o_code.valid   = r_out_valid;
    assign o_code.code    = r_code;
    assign in_acc         = i_sample.valid && (r_state == S_IDLE);
    assign out_acc        = r_out_valid && o_code.ready;
    assign slot_free      = !r_out_valid || o_code.ready;

    // Clamp the window length into 1 .. MAX_WINDOW
    always_comb begin
        if (r_win_len == '0) begin
            wl_eff = WIN_W'(1);
        end else if (r_win_len > WIN_W'(MAX_WINDOW)) begin
            wl_eff = WIN_W'(MAX_WINDOW);
        end else begin
            wl_eff = r_win_len;
        end
    end

    // Prediction error and its magnitude for the divider
    assign diff     = (ACC_W+1)'(r_sample) - {r_pred[ACC_W-1], r_pred};
    assign diff_mag = diff[ACC_W] ? (~diff + 1'b1) : diff;

    // Truncated quotient, clipped against code_max first, then against code_min
    assign quot_lo = div_quot[ACC_W-1:0];
    assign neg_lim = ~r_code_min + 1'b1;
    always_comb begin
        if (!r_neg) begin
            if (quot_lo > ACC_W'(r_code_max)) begin
                n_z = CODE_W'({1'b0, r_code_max});
            end else if (!r_code_min[7] && (quot_lo < ACC_W'(r_code_min[6:0]))) begin
                n_z = r_code_min;
            end else begin
                n_z = quot_lo[CODE_W-1:0];
            end
        end else begin
            if (!r_code_min[7] || (quot_lo > ACC_W'(neg_lim))) begin
                n_z = r_code_min;
            end else begin
                n_z = ~quot_lo[CODE_W-1:0] + 1'b1;
            end
        end
    end

    // Dequantised difference, saturated to 40 bits
    assign step_s = {1'b0, r_step};
    always_comb begin
        if (!r_prod[ACC_W+8] && (r_prod[ACC_W+7:ACC_W-1] != '0)) begin
            n_dq = {1'b0, {(ACC_W-1){1'b1}}};
        end else if (r_prod[ACC_W+8] && (r_prod[ACC_W+7:ACC_W-1] != '1)) begin
            n_dq = {1'b1, {(ACC_W-1){1'b0}}};
        end else begin
            n_dq = r_prod[ACC_W-1:0];
        end
    end

    // History pointer arithmetic, wrapping at MAX_WINDOW
    assign pos_nxt = (r_pos == HIST_AW'(MAX_WINDOW - 1)) ? '0 : r_pos + 1'b1;
    assign idx_dec = (r_idx == '0) ? HIST_AW'(MAX_WINDOW - 1) : r_idx - 1'b1;

    // Next prediction: reconstruction shifted, rounded half up by 2^15, saturated
    assign recon_sh  = (ACC_W+16)'(r_recon) <<< r_pred_shift;
    assign recon_rnd = (ACC_W+17)'(recon_sh) + (ACC_W+17)'(16384);
    assign pred_q    = recon_rnd[ACC_W+16:15];
    always_comb begin
        if (!pred_q[ACC_W+1] && (pred_q[ACC_W:ACC_W-1] != 2'b00)) begin
            n_pred = {1'b0, {(ACC_W-1){1'b1}}};
        end else if (pred_q[ACC_W+1] && (pred_q[ACC_W:ACC_W-1] != 2'b11)) begin
            n_pred = {1'b1, {(ACC_W-1){1'b0}}};
        end else begin
            n_pred = pred_q[ACC_W-1:0];
        end
    end

    // Window walk: issue one read per cycle, accumulate the magnitude in the next cycle
    assign issue    = (r_state == S_SUM) && (r_cnt < wl_eff);
    assign rd_en    = issue;
    assign sum_done = (r_state == S_SUM) && !issue && !r_pend;
    assign hist_v   = r_rd_vld ? r_rd_data : '0;
    assign hist_abs = hist_v[ACC_W-1] ? (~hist_v + 1'b1) : hist_v;

    // Next step: mean rounded by 2^15, floored, saturated to 40 bits unsigned
    assign power_rnd = {1'b0, div_quot} + (DIVD_W+1)'(16384);
    assign ns        = power_rnd[DIVD_W:15];
    assign step_fl   = (r_step_floor == '0) ? 16'd1 : r_step_floor;
    always_comb begin
        if (ns < (DIVD_W-14)'(step_fl)) begin
            n_step = ACC_W'(step_fl);
        end else if (ns[DIVD_W-15:ACC_W] != '0) begin
            n_step = '1;
        end else begin
            n_step = ns[ACC_W-1:0];
        end
    end

    // Divider requests: prediction error over step, then scaled window sum over its length
    always_comb begin
        div_req.start = (r_state == S_DIFF) || sum_done;
        if (r_state == S_DIFF) begin
            div_req.iters = DIV_CNT_W'(ACC_W);
            div_dividend  = {diff_mag[ACC_W-1:0], {(DIVD_W-ACC_W){1'b0}}};
            div_divisor   = r_step;
        end else begin
            div_req.iters = DIV_CNT_W'(DIVD_W);
            div_dividend  = DIVD_W'(r_sum) << r_adapt_shift;
            div_divisor   = DIVS_W'(wl_eff);
        end
    end

    adpcm_ase_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_max    <= RST_CODE_MAX;
            r_code_min    <= RST_CODE_MIN;
            r_pred_shift  <= RST_PREDICT_SHIFT;
            r_adapt_shift <= RST_ADAPT_SHIFT;
            r_win_len     <= RST_WINDOW_LENGTH;
            r_step_floor  <= RST_STEP_FLOOR;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_CODE_MAX:      r_code_max    <= i_cfg.data[6:0];
                REG_CODE_MIN:      r_code_min    <= i_cfg.data[7:0];
                REG_PREDICT_SHIFT: r_pred_shift  <= i_cfg.data[SH_W-1:0];
                REG_ADAPT_SHIFT:   r_adapt_shift <= i_cfg.data[SH_W-1:0];
                REG_WINDOW_LENGTH: r_win_len     <= i_cfg.data[WIN_W-1:0];
                REG_STEP_FLOOR:    r_step_floor  <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    // Sequencer and encoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pred      <= '0;
            r_step      <= ACC_W'(RST_STEP_FLOOR);
            r_pos       <= '0;
            r_hvalid    <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // load a new code when the slot frees, else drop the one taken
            if ((r_state == S_MUL) && slot_free) begin
                r_out_valid <= 1'b1;
            end else if (out_acc) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_state <= S_DIFF;
                    end
                end
                S_DIFF: begin
                    r_state <= S_DIV1;
                end
                S_DIV1: begin
                    if (div_done) begin
                        r_state <= S_CLIP;
                    end
                end
                S_CLIP: begin
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    // hold until the output register is free
                    if (slot_free) begin
                        r_state <= S_WR;
                    end
                end
                S_WR: begin
                    r_pos           <= pos_nxt;
                    r_hvalid[pos_nxt] <= 1'b1;
                    r_pend          <= 1'b0;
                    r_state         <= S_PRED;
                end
                S_PRED: begin
                    r_pred  <= n_pred;
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_pend <= issue;
                    if (sum_done) begin
                        r_state <= S_DIV2;
                    end
                end
                S_DIV2: begin
                    if (div_done) begin
                        r_state <= S_STEP;
                    end
                end
                S_STEP: begin
                    r_step  <= n_step;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_sample <= i_sample.sample;
        end
        if (r_state == S_DIFF) begin
            r_neg <= diff[ACC_W];
        end
        if (r_state == S_CLIP) begin
            r_z <= n_z;
        end
        if ((r_state == S_MUL) && slot_free) begin
            r_prod <= step_s * r_z;
            r_code <= r_z;
        end
        if (r_state == S_WR) begin
            r_recon <= (ACC_W+1)'(n_dq) + {r_pred[ACC_W-1], r_pred};
            r_idx   <= pos_nxt;
            r_cnt   <= '0;
            r_sum   <= '0;
        end
        if (r_state == S_SUM) begin
            if (issue) begin
                r_idx <= idx_dec;
                r_cnt <= r_cnt + 1'b1;
            end
            if (r_pend) begin
                r_sum <= r_sum + SUM_W'(hist_abs);
            end
        end
    end

    // History memory: write the new difference, read one entry per walk cycle
    always_ff @(posedge i_clk) begin
        if (r_state == S_WR) begin
            r_hist[pos_nxt] <= n_dq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_hist[r_idx];
            r_rd_vld  <= r_hvalid[r_idx];
        end
    end

endmodule

// ----- hw/rtl/adpcm_ase_chk.sv -----
// Port-level checker for the ADPCM step encoder, bound to the top level.
module adpcm_ase_chk import adpcm_ase_pkg::*; (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_in_valid,
    input logic                     i_in_ready,
    input logic                     i_out_valid,
    input logic                     i_out_ready,
    input logic signed [CODE_W-1:0] i_out_code
);

    logic [1:0] r_open;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = i_in_valid && i_in_ready;
    assign out_acc = i_out_valid && i_out_ready;

    // Track items accepted whose code has not yet been taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= '0;
        end else if (in_acc && !out_acc) begin
            r_open <= r_open + 1'b1;
        end else if (out_acc && !in_acc) begin
            r_open <= r_open - 1'b1;
        end
    end

    // A stalled code holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_code))
        else $error("code changed or dropped while stalled");

    // One item at a time: the sample channel closes after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !i_in_ready)
        else $error("sample accepted while an item is in work");

    // No code without a sample behind it
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_open != 2'd0)
        else $error("code presented with no sample outstanding");

    // At most one finished code plus one item in work
    a_open_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_open != 2'd3)
        else $error("too many items outstanding");

    // Reset empties the output register
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("code valid after reset");

endmodule

bind adpcm_adaptive_step_encoder_unit adpcm_ase_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_sample.valid),
    .i_in_ready  (i_sample.ready),
    .i_out_valid (o_code.valid),
    .i_out_ready (o_code.ready),
    .i_out_code  (o_code.code)
);

// ----- sim/adpcm_adaptive_step_encoder_unit_tb.sv -----
// Self-checking testbench for the backward-adaptive ADPCM step encoder of one subband.
module adpcm_adaptive_step_encoder_unit_tb;
    import adpcm_ase_pkg::*;

    localparam int SETTLE_CYCLES = 256;
    localparam int STALL_LIMIT   = 5000;
    localparam int NUM_PHASES    = 12;
    localparam int PHASE_ITEMS   = 78;
    localparam int MAX_REPORTS   = 10;

    // Indexes past the last register, which the block must ignore
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam longint S40_HI = (longint'(1) << 39) - 1;
    localparam longint S40_LO = -(longint'(1) << 39);
    localparam longint U40_HI = (longint'(1) << 40) - 1;

    typedef logic signed [CODE_W-1:0]   code_t;
    typedef logic signed [SAMPLE_W-1:0] sample_t;

    typedef enum logic {ROW_CFG, ROW_SAMPLE} row_kind_e;

    typedef struct packed {
        row_kind_e             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        sample_t               smp;
        logic                  has_code;
        code_t                 code;
    } dir_row_t;

    logic i_clk;
    logic i_rst_n;

    adpcm_ase_sample_if smp_if ();
    adpcm_ase_code_if   code_if ();
    adpcm_ase_cfg_if    cfg_if ();

    adpcm_adaptive_step_encoder_unit uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (smp_if),
        .o_code   (code_if),
        .i_cfg    (cfg_if)
    );

    // Encoder mirror: configuration and adaptation state
    longint cfg_code_max;
    longint cfg_code_min;
    int     cfg_pshift;
    int     cfg_ashift;
    int     cfg_wlen;
    longint cfg_floor;
    longint pred_acc;
    longint step_acc;
    longint diff_hist [MAX_WINDOW];
    int     hist_wr;

    code_t    pending_codes [$];
    dir_row_t dir_tab [$];
    int       mismatches;
    int       codes_seen;
    int       idle_cycles;
    bit       no_idle;

    function automatic longint sat40(input longint x);
        if (x > S40_HI) return S40_HI;
        if (x < S40_LO) return S40_LO;
        return x;
    endfunction

    // Scale by 2^-15, rounding half up
    function automatic longint round_q15(input longint x);
        return (x + 64'sd16384) >>> 15;
    endfunction

    function automatic void reset_mirror();
        cfg_code_max = longint'(RST_CODE_MAX);
        cfg_code_min = longint'(RST_CODE_MIN);
        cfg_pshift   = int'(RST_PREDICT_SHIFT);
        cfg_ashift   = int'(RST_ADAPT_SHIFT);
        cfg_wlen     = int'(RST_WINDOW_LENGTH);
        cfg_floor    = longint'(RST_STEP_FLOOR);
        pred_acc     = 0;
        step_acc     = longint'(RST_STEP_FLOOR);
        foreach (diff_hist[i]) diff_hist[i] = 0;
        hist_wr      = 0;
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] d);
        case (idx)
            REG_CODE_MAX:      cfg_code_max = longint'(d[6:0]);
            REG_CODE_MIN:      cfg_code_min = longint'($signed(d[7:0]));
            REG_PREDICT_SHIFT: cfg_pshift   = int'(d[3:0]);
            REG_ADAPT_SHIFT:   cfg_ashift   = int'(d[3:0]);
            REG_WINDOW_LENGTH: cfg_wlen     = int'(d[5:0]);
            REG_STEP_FLOOR:    cfg_floor    = longint'(d);
            default: ;
        endcase
    endfunction

    // Quantise one sample, then advance prediction, history and step
    function automatic code_t encode_sample(input sample_t s);
        longint stp, z, dq, recon, sum, power, ns, fl, v;
        int     wl, idx;
        stp = (step_acc < 1) ? 1 : step_acc;
        z = (longint'(s) - pred_acc) / stp;
        if (z > cfg_code_max) begin
            z = cfg_code_max;
        end else if (z < cfg_code_min) begin
            z = cfg_code_min;
        end
        dq = sat40(stp * z);
        hist_wr = (hist_wr + 1 >= MAX_WINDOW) ? 0 : hist_wr + 1;
        diff_hist[hist_wr] = dq;

        recon = dq + pred_acc;
        pred_acc = sat40(round_q15(recon * (longint'(1) << cfg_pshift)));

        // Walk the window backwards from the newest difference
        wl = cfg_wlen;
        if (wl < 1) wl = 1;
        if (wl > MAX_WINDOW) wl = MAX_WINDOW;
        sum = 0;
        idx = hist_wr;
        for (int i = 0; i < wl; i++) begin
            v = diff_hist[idx];
            sum += (v < 0) ? -v : v;
            idx = (idx == 0) ? MAX_WINDOW - 1 : idx - 1;
        end
        power = (sum * (longint'(1) << cfg_ashift)) / longint'(wl);
        ns = round_q15(power);
        fl = (cfg_floor < 1) ? 1 : cfg_floor;
        if (ns < fl) ns = fl;
        if (ns > U40_HI) ns = U40_HI;
        step_acc = ns;
        return z[7:0];
    endfunction

    function automatic int pick(input int lo, input int hi);
        case ($urandom_range(0, 3))
            0:       return lo;
            1:       return hi;
            default: return lo + int'($urandom_range(0, hi - lo));
        endcase
    endfunction

    function automatic dir_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] d);
        return '{ROW_CFG, idx, d, 16'sd0, 1'b0, 8'sd0};
    endfunction

    function automatic dir_row_t smp_row(input sample_t s);
        return '{ROW_SAMPLE, REG_CODE_MAX, 16'd0, s, 1'b0, 8'sd0};
    endfunction

    function automatic dir_row_t chk_row(input sample_t s, input code_t c);
        return '{ROW_SAMPLE, REG_CODE_MAX, 16'd0, s, 1'b1, c};
    endfunction

    // Write one register; valid stays high so that writes can follow back to back
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] d);
        cfg_if.index <= idx;
        cfg_if.data  <= d;
        cfg_if.valid <= 1'b1;
        do @(posedge i_clk); while (!cfg_if.ready);
        apply_reg(idx, d);
    endtask

    // Offer one sample item after an optional gap, and queue its code once taken
    task automatic send_sample(input sample_t s, input bit has_code, input code_t c,
                               input int gap_pct);
        code_t predicted;
        if (!no_idle && $urandom_range(0, 99) < gap_pct) begin
            smp_if.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        smp_if.valid  <= 1'b1;
        smp_if.sample <= s;
        do @(posedge i_clk); while (!smp_if.ready);
        predicted = encode_sample(s);
        pending_codes.push_back(has_code ? c : predicted);
    endtask

    // Hold the sender until every queued code has come back
    task automatic drain();
        smp_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending_codes.size() != 0);
    endtask

    // Drain, then let the step adaptation of the last item finish
    task automatic wait_idle();
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: ready in random bursts, always ready in the final phase
    initial begin
        int  left;
        bit  stall;
        left = 0;
        stall = 1'b0;
        code_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (left == 0) begin
                if (!no_idle && $urandom_range(0, 2) == 0) begin
                    stall = 1'b1;
                    left = $urandom_range(1, 15);
                end else begin
                    stall = 1'b0;
                    left = $urandom_range(1, 40);
                end
            end
            left--;
            code_if.ready <= !stall;
        end
    end

    // Compare each code taken with the oldest one pending
    always @(posedge i_clk) begin
        if (i_rst_n && code_if.valid && code_if.ready) begin
            if (pending_codes.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("code %0d arrived with nothing pending", code_if.code);
            end else begin
                if (code_if.code !== pending_codes[0]) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("code %0d: expected %0d, got %0d",
                                 codes_seen, pending_codes[0], code_if.code);
                end
                void'(pending_codes.pop_front());
            end
            codes_seen++;
        end
    end

    // Watchdog: end the run when no channel moves an item for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (smp_if.valid && smp_if.ready) || (code_if.valid && code_if.ready)
                || (cfg_if.valid && cfg_if.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("adpcm_adaptive_step_encoder_unit_tb NOT OK");
            $finish;
        end
    end

    initial begin
        int              cmax, cmin, psh, ash, wl, fl, gap, walk;
        logic [CFG_DATA_W-1:0] d;
        sample_t         s;
        row_kind_e       prev_kind;

        mismatches = 0;
        codes_seen = 0;
        idle_cycles = 0;
        no_idle = 1'b0;
        walk = 0;
        reset_mirror();

        i_rst_n       <= 1'b0;
        smp_if.valid  <= 1'b0;
        smp_if.sample <= '0;
        cfg_if.valid  <= 1'b0;
        cfg_if.index  <= '0;
        cfg_if.data   <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows: defaults after reset, extremes, clip order, odd register values
        dir_tab.push_back(chk_row(16'sd0, 8'sd0));
        dir_tab.push_back(chk_row(16'sd32767, 8'sd7));
        dir_tab.push_back(chk_row(-16'sd32768, -8'sd8));
        dir_tab.push_back(smp_row(16'sd1));
        dir_tab.push_back(smp_row(-16'sd1));
        dir_tab.push_back(cfg_row(REG_CODE_MAX, 16'h007F));
        dir_tab.push_back(cfg_row(REG_CODE_MIN, 16'h0080));
        dir_tab.push_back(cfg_row(REG_PREDICT_SHIFT, 16'h000F));
        dir_tab.push_back(cfg_row(REG_ADAPT_SHIFT, 16'h000F));
        dir_tab.push_back(cfg_row(REG_WINDOW_LENGTH, 16'h0001));
        dir_tab.push_back(cfg_row(REG_STEP_FLOOR, 16'hFFFF));
        dir_tab.push_back(smp_row(16'sd32767));
        dir_tab.push_back(smp_row(-16'sd32768));
        dir_tab.push_back(smp_row(16'sd32767));
        dir_tab.push_back(smp_row(16'sd0));
        // Zero floor and zero window both act as one
        dir_tab.push_back(cfg_row(REG_STEP_FLOOR, 16'h0000));
        dir_tab.push_back(cfg_row(REG_WINDOW_LENGTH, 16'h0000));
        dir_tab.push_back(cfg_row(REG_PREDICT_SHIFT, 16'h0000));
        dir_tab.push_back(cfg_row(REG_ADAPT_SHIFT, 16'h0000));
        dir_tab.push_back(smp_row(16'sd32767));
        dir_tab.push_back(smp_row(-16'sd32768));
        dir_tab.push_back(smp_row(16'sd100));
        // Both limits at zero pin every code to zero
        dir_tab.push_back(cfg_row(REG_CODE_MAX, 16'h0000));
        dir_tab.push_back(cfg_row(REG_CODE_MIN, 16'h0000));
        dir_tab.push_back(chk_row(16'sd1234, 8'sd0));
        dir_tab.push_back(chk_row(-16'sd4321, 8'sd0));
        // Lower limit above zero pins the code at 127 and drives every sum to saturation
        dir_tab.push_back(cfg_row(REG_CODE_MAX, 16'h007F));
        dir_tab.push_back(cfg_row(REG_CODE_MIN, 16'h007F));
        dir_tab.push_back(cfg_row(REG_PREDICT_SHIFT, 16'h000F));
        dir_tab.push_back(cfg_row(REG_ADAPT_SHIFT, 16'h000F));
        dir_tab.push_back(cfg_row(REG_WINDOW_LENGTH, 16'h0001));
        dir_tab.push_back(cfg_row(REG_STEP_FLOOR, 16'h0001));
        dir_tab.push_back(chk_row(16'sd32767, 8'sd127));
        dir_tab.push_back(chk_row(-16'sd32768, 8'sd127));
        dir_tab.push_back(chk_row(16'sd0, 8'sd127));
        dir_tab.push_back(chk_row(16'sd32767, 8'sd127));
        dir_tab.push_back(chk_row(-16'sd32768, 8'sd127));
        dir_tab.push_back(chk_row(16'sd5, 8'sd127));
        dir_tab.push_back(chk_row(-16'sd5, 8'sd127));
        // Over-long window acts as the full history; spare indexes change nothing
        dir_tab.push_back(cfg_row(REG_WINDOW_LENGTH, 16'h003F));
        dir_tab.push_back(cfg_row(REG_CODE_MIN, 16'h0080));
        dir_tab.push_back(cfg_row(REG_SPARE_LO, 16'hFFFF));
        dir_tab.push_back(cfg_row(REG_SPARE_HI, 16'h5555));
        dir_tab.push_back(smp_row(16'sd32767));
        dir_tab.push_back(smp_row(-16'sd32768));
        dir_tab.push_back(smp_row(16'sd0));

        // Walk the directed rows; registers change only while the block is idle
        prev_kind = ROW_CFG;
        foreach (dir_tab[i]) begin
            if (dir_tab[i].kind == ROW_CFG) begin
                if (prev_kind == ROW_SAMPLE) wait_idle();
                write_reg(dir_tab[i].idx, dir_tab[i].data);
            end else begin
                if (prev_kind == ROW_CFG) cfg_if.valid <= 1'b0;
                send_sample(dir_tab[i].smp, dir_tab[i].has_code, dir_tab[i].code, 20);
            end
            prev_kind = dir_tab[i].kind;
        end

        // Random phases, each with its own register setting
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_idle();
            no_idle = (ph == NUM_PHASES - 1);
            case (ph)
                0: begin
                    cmax = 127; cmin = -128; psh = 15; ash = 15; wl = 32; fl = 1;
                end
                1: begin
                    cmax = 127; cmin = 127; psh = 15; ash = 15; wl = 1; fl = 1;
                end
                2: begin
                    cmax = 0; cmin = -128; psh = 0; ash = 0; wl = 63; fl = 65535;
                end
                default: begin
                    cmax = pick(0, 127);
                    cmin = ($urandom_range(0, 7) == 0) ? int'($urandom_range(1, 127))
                                                        : pick(-128, 0);
                    psh  = pick(0, 15);
                    ash  = pick(0, 15);
                    wl   = pick(0, 63);
                    fl   = ($urandom_range(0, 3) == 0) ? pick(0, 65535)
                                                        : int'($urandom_range(0, 64));
                end
            endcase

            // Keep the unused upper data bits random
            d = 16'($urandom()); d[6:0] = 7'(cmax);
            write_reg(REG_CODE_MAX, d);
            d = 16'($urandom()); d[7:0] = 8'(cmin);
            write_reg(REG_CODE_MIN, d);
            d = 16'($urandom()); d[3:0] = 4'(psh);
            write_reg(REG_PREDICT_SHIFT, d);
            d = 16'($urandom()); d[3:0] = 4'(ash);
            write_reg(REG_ADAPT_SHIFT, d);
            d = 16'($urandom()); d[5:0] = 6'(wl);
            write_reg(REG_WINDOW_LENGTH, d);
            write_reg(REG_STEP_FLOOR, 16'(fl));
            if ($urandom_range(0, 2) == 0)
                write_reg(($urandom_range(0, 1) == 0) ? REG_SPARE_LO : REG_SPARE_HI,
                          16'($urandom()));
            cfg_if.valid <= 1'b0;

            case ($urandom_range(0, 2))
                0:       gap = 0;
                1:       gap = 15;
                default: gap = 50;
            endcase

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Mix full-range noise, small values, extremes and a slow walk
                case ($urandom_range(0, 9))
                    0, 1, 2: s = sample_t'($urandom());
                    3, 4:    s = sample_t'(int'($urandom_range(0, 64)) - 32);
                    5: begin
                        case ($urandom_range(0, 4))
                            0:       s = 16'sd32767;
                            1:       s = -16'sd32768;
                            2:       s = 16'sd1;
                            3:       s = -16'sd1;
                            default: s = 16'sd0;
                        endcase
                    end
                    default: begin
                        walk += int'($urandom_range(0, 4000)) - 2000;
                        if (walk > 32767) walk = 32767;
                        if (walk < -32768) walk = -32768;
                        s = sample_t'(walk);
                    end
                endcase
                send_sample(s, 1'b0, 8'sd0, gap);
                // Hold the sender once until every queued code has come back
                if (ph == 3 && n == PHASE_ITEMS / 2) drain();
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_codes.size() == 0) begin
            $display("adpcm_adaptive_step_encoder_unit_tb OK");
        end else begin
            $display("adpcm_adaptive_step_encoder_unit_tb NOT OK");
        end
        $finish;
    end

endmodule
